@@ design/iss_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Shared widths, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package iss_pkg;

    localparam int CAPACITY = 256;
    localparam int POS_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 9;
    localparam int VAL_W    = 32;
    localparam int STS_W    = 3;
    localparam int LEN_W    = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_BAD_INDEX = 3'd1,
        STS_FULL      = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_EVAL,
        ST_SHIFT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic                    ins_en;
        logic                    cmp_en;
        logic                    del_en;
        logic [IDX_W-1:0]        ins_idx;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

@@ design/iss_cmd_if.sv @@
// ----------------------------------------------------------------------------
// Command channel
// Carries one command transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface iss_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [iss_pkg::CMD_W-1:0]       cmd;
    logic [iss_pkg::IDX_W-1:0]       index;
    logic signed [iss_pkg::VAL_W-1:0] value;

    modport source (output valid, output cmd, output index, output value, input ready);
    modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

@@ design/iss_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Carries one result transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface iss_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [iss_pkg::STS_W-1:0] status;
    logic                      found;
    logic [iss_pkg::LEN_W-1:0] length;

    modport source (output valid, output status, output found, output length, input ready);
    modport sink   (input valid, input status, input found, input length, output ready);
endinterface

@@ design/indexed_sequence_store_core.sv @@
// ----------------------------------------------------------------------------
// Indexed sequence store core
// Ordered store of signed values held in a row of cells that shift together.
// ----------------------------------------------------------------------------
// Steps: insert and clear go straight to the result step after acceptance;
// find runs compare and evaluate first, and delete adds a shift step when
// entries behind the match must move. A command is taken only while idle,
// after the last result is loaded for output. Reset empties the store; entry
// data is not cleared and is only read below the current length.
// ----------------------------------------------------------------------------
module indexed_sequence_store_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iss_cmd_if.sink     i_cmd,
    iss_rsp_if.source   o_rsp
);

    localparam int CAP = iss_pkg::CAPACITY;

    iss_pkg::t_state                  r_state, n_state;
    logic [iss_pkg::CNT_W-1:0]        r_count, n_count;
    logic signed [iss_pkg::VAL_W-1:0] r_val, n_val;
    iss_pkg::t_cmd                    r_cmd, n_cmd;
    iss_pkg::t_status                 r_status, n_status;
    logic                             r_found, n_found;
    logic [CAP-1:0]                   r_ge, n_ge;
    logic                             r_out_valid, n_out_valid;
    iss_pkg::t_status                 r_out_status, n_out_status;
    logic                             r_out_found, n_out_found;
    logic [iss_pkg::LEN_W-1:0]        r_out_length, n_out_length;

    iss_pkg::t_cell_ctl               w_ctl;
    logic signed [iss_pkg::VAL_W-1:0] w_data [CAP];
    logic [CAP-1:0]                   w_eq;
    logic [CAP-1:0]                   w_valid;
    logic [CAP-1:0]                   w_tail;
    logic [CAP-1:0]                   w_match;
    logic [CAP-1:0]                   w_match_ge;
    logic                             w_any;
    logic                             w_tail_hit;
    logic                             w_head_hit;
    logic                             w_acc;
    logic                             w_load;
    iss_pkg::t_cmd                    w_in_cmd;

    always_comb begin
        for (int k = 0; k < CAP; k++) begin
            w_valid[k] = 32'(k) < 32'(r_count);
            w_tail[k]  = 32'(k + 1) == 32'(r_count);
        end
    end

    assign w_match    = w_eq & w_valid;
    assign w_match_ge = w_match | (~w_match + CAP'(1));
    assign w_any      = |w_match;
    assign w_tail_hit = |(w_eq & w_tail);
    assign w_head_hit = w_match[0];

    assign w_in_cmd      = iss_pkg::t_cmd'(i_cmd.cmd);
    assign i_cmd.ready   = (r_state == iss_pkg::ST_IDLE);
    assign w_acc         = i_cmd.valid && i_cmd.ready;
    assign w_load        = (r_state == iss_pkg::ST_RESULT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        w_ctl         = '0;
        w_ctl.ins_idx = i_cmd.index;
        w_ctl.value   = (r_state == iss_pkg::ST_IDLE) ? i_cmd.value : r_val;
        w_ctl.cmp_en  = (r_state == iss_pkg::ST_CMP);
        w_ctl.del_en  = (r_state == iss_pkg::ST_SHIFT);
        w_ctl.ins_en  = w_acc && (w_in_cmd == iss_pkg::CMD_INSERT)
                        && (32'(i_cmd.index) <= 32'(r_count))
                        && (32'(r_count) < 32'(CAP));
    end

    for (genvar k = 0; k < CAP; k++) begin : g_cell
        logic signed [iss_pkg::VAL_W-1:0] w_left;
        logic signed [iss_pkg::VAL_W-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = w_ctl.value;
        end else begin : g_mid
            assign w_left = w_data[k-1];
        end
        if (k == CAP - 1) begin : g_last
            assign w_right = w_data[k];
        end else begin : g_inner
            assign w_right = w_data[k+1];
        end
        iss_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (iss_pkg::POS_W'(k)),
            .i_left  (w_left),
            .i_right (w_right),
            .i_ge    (r_ge[k]),
            .o_data  (w_data[k]),
            .o_eq    (w_eq[k])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_val        = r_val;
        n_cmd        = r_cmd;
        n_status     = r_status;
        n_found      = r_found;
        n_ge         = r_ge;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_length = r_out_length;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            iss_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_cmd    = w_in_cmd;
                    n_val    = i_cmd.value;
                    n_status = iss_pkg::STS_OK;
                    n_found  = 1'b0;
                    n_state  = iss_pkg::ST_RESULT;
                    case (w_in_cmd)
                        iss_pkg::CMD_INSERT: begin
                            if (32'(i_cmd.index) > 32'(r_count)) begin
                                n_status = iss_pkg::STS_BAD_INDEX;
                            end else if (32'(r_count) >= 32'(CAP)) begin
                                n_status = iss_pkg::STS_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        iss_pkg::CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_status = iss_pkg::STS_EMPTY;
                            end else begin
                                n_state = iss_pkg::ST_CMP;
                            end
                        end
                        iss_pkg::CMD_FIND: begin
                            n_state = iss_pkg::ST_CMP;
                        end
                        iss_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            iss_pkg::ST_CMP: begin
                n_state = iss_pkg::ST_EVAL;
            end
            iss_pkg::ST_EVAL: begin
                n_state = iss_pkg::ST_RESULT;
                if (r_cmd == iss_pkg::CMD_FIND) begin
                    n_found = w_any;
                end else if (w_head_hit) begin
                    n_ge    = w_match_ge;
                    n_state = iss_pkg::ST_SHIFT;
                end else if (w_tail_hit) begin
                    n_count = r_count - 1'b1;
                end else if (w_any) begin
                    n_ge    = w_match_ge;
                    n_state = iss_pkg::ST_SHIFT;
                end else begin
                    n_status = iss_pkg::STS_NOT_FOUND;
                end
            end
            iss_pkg::ST_SHIFT: begin
                n_count = r_count - 1'b1;
                n_state = iss_pkg::ST_RESULT;
            end
            iss_pkg::ST_RESULT: begin
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_length = iss_pkg::LEN_W'(r_count);
                    n_state      = iss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iss_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_cmd        <= n_cmd;
        r_status     <= n_status;
        r_found      <= n_found;
        r_ge         <= n_ge;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_length <= n_out_length;
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.found  = r_out_found;
    assign o_rsp.length = r_out_length;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(CAP))
        else $error("Entry count exceeds capacity.");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_in_cmd == iss_pkg::CMD_CLEAR) |=> (r_count == '0))
        else $error("Clear did not empty the store.");

    a_bad_insert_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_in_cmd == iss_pkg::CMD_INSERT
         && 32'(i_cmd.index) > 32'(r_count)) |=> (r_count == $past(r_count)))
        else $error("Rejected insert changed the length.");

    a_length_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (32'(o_rsp.length) == 32'(r_count)))
        else $error("Reported length differs from the entry count.");

endmodule

@@ design/iss_cell.sv @@
// ----------------------------------------------------------------------------
// Sequence store cell
// Holds one entry, shifts it with its neighbors and compares it to a value.
// ----------------------------------------------------------------------------
module iss_cell (
    input  logic                              i_clk,
    input  iss_pkg::t_cell_ctl                i_ctl,
    input  logic [iss_pkg::POS_W-1:0]         i_pos,
    input  logic signed [iss_pkg::VAL_W-1:0]  i_left,
    input  logic signed [iss_pkg::VAL_W-1:0]  i_right,
    input  logic                              i_ge,
    output logic signed [iss_pkg::VAL_W-1:0]  o_data,
    output logic                              o_eq
);

    logic signed [iss_pkg::VAL_W-1:0] r_data;
    logic signed [iss_pkg::VAL_W-1:0] n_data;
    logic                             r_eq;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins_en) begin
            if (32'(i_pos) == 32'(i_ctl.ins_idx)) begin
                n_data = i_ctl.value;
            end else if (32'(i_pos) > 32'(i_ctl.ins_idx)) begin
                n_data = i_left;
            end
        end else if (i_ctl.del_en && i_ge) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.cmp_en) begin
            r_eq <= (r_data == i_ctl.value);
        end
    end

    assign o_data = r_data;
    assign o_eq   = r_eq;

endmodule
